FILE: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types for the modular exponentiation core and its multiplier unit
// ----------------------------------------------------------------------------
package mexp_pkg;

  // command from the exponent sequencer to the modular multiplier
  typedef struct packed {
    logic start;
    logic square;
  } mm_cmd_t;

endpackage

FILE: design/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// bit-serial modular multiplier: doubles and adds under the modulus, msb first,
// one modular add per cycle
// ----------------------------------------------------------------------------
module mexp_modmul
  import mexp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mm_cmd_t                cmd_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  input  logic [VALUE_WIDTH-1:0] m_i,
  output logic [VALUE_WIDTH-1:0] result_o,
  output logic                   done_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DBL,
    S_ADD
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [VALUE_WIDTH-1:0] a_q;
  logic [VALUE_WIDTH-1:0] b_q;
  logic [VALUE_WIDTH-1:0] m_q;
  logic [CntWidth-1:0]    cnt_q;
  logic                   done_q;
  logic [VALUE_WIDTH-1:0] addend;
  logic [VALUE_WIDTH-1:0] sum;

  // (x + y) mod m for x, y below m
  function automatic logic [VALUE_WIDTH-1:0] add_mod(input logic [VALUE_WIDTH-1:0] x,
                                                     input logic [VALUE_WIDTH-1:0] y,
                                                     input logic [VALUE_WIDTH-1:0] m);
    logic [VALUE_WIDTH-1:0] room;
    begin
      room = m - y;
      add_mod = (x >= room) ? (x - room) : (x + y);
    end
  endfunction

  assign addend = (state_q == S_ADD) ? a_q : acc_q;
  assign sum    = add_mod(acc_q, addend, m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      m_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            acc_q   <= '0;
            a_q     <= a_i;
            b_q     <= cmd_i.square ? a_i : b_i;
            m_q     <= m_i;
            cnt_q   <= CntWidth'(VALUE_WIDTH - 1);
            state_q <= S_DBL;
          end
        end
        S_DBL: begin
          acc_q <= sum;
          if (b_q[VALUE_WIDTH-1]) begin
            state_q <= S_ADD;
          end else begin
            b_q <= b_q << 1;
            if (cnt_q == '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        S_ADD: begin
          acc_q <= sum;
          b_q   <= b_q << 1;
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_DBL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o = acc_q;
  assign done_o   = done_q;

endmodule

FILE: design/modular_exponentiation_core.sv
// work: up to (2*EXP_WIDTH + 1) modular products: one reduces the base, then each
// exponent bit squares and, when the bit is set, multiplies first
// throughput: one transaction at a time, the shared bit-serial multiplier sets the pace
// zero exponent or zero modulus skips the multiplier and goes through S_BIT and S_DONE to the result
// reset: asynchronous active low, clears the sequencer and the output valid
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// right-to-left square-and-multiply sequencer around one modular multiplier
// ----------------------------------------------------------------------------
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned EXP_WIDTH   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] base_i,
  input  logic [EXP_WIDTH-1:0]   exponent_i,
  input  logic [VALUE_WIDTH-1:0] modulus_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] power_mod_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_BIT,
    S_MUL,
    S_SQR,
    S_DONE
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [VALUE_WIDTH-1:0] sq_q;
  logic [VALUE_WIDTH-1:0] mod_q;
  logic [EXP_WIDTH-1:0]   exp_q;
  mm_cmd_t                cmd_q;
  logic [VALUE_WIDTH-1:0] op_a_q;
  logic [VALUE_WIDTH-1:0] op_b_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] power_mod_q;
  logic [VALUE_WIDTH-1:0] mm_result;
  logic                   mm_done;
  logic                   in_accept;
  logic                   out_free;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  mexp_modmul #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .m_i     (mod_q),
    .result_o(mm_result),
    .done_o  (mm_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      sq_q        <= '0;
      mod_q       <= '0;
      exp_q       <= '0;
      op_a_q      <= '0;
      op_b_q      <= '0;
      power_mod_q <= '0;
    end else begin
      cmd_q <= '0;
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mod_q <= modulus_i;
            exp_q <= exponent_i;
            if (exponent_i == '0) begin
              acc_q   <= VALUE_WIDTH'(1);
              state_q <= S_BIT;
            end else if (modulus_i == '0) begin
              acc_q   <= '0;
              exp_q   <= '0;
              state_q <= S_BIT;
            end else begin
              // base mod m as the product 1 * base
              cmd_q   <= '{start: 1'b1, square: 1'b0};
              op_a_q  <= VALUE_WIDTH'(1);
              op_b_q  <= base_i;
              state_q <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_done) begin
            sq_q    <= mm_result;
            acc_q   <= (mod_q == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
            state_q <= S_BIT;
          end
        end
        S_BIT: begin
          if (exp_q == '0) begin
            state_q <= S_DONE;
          end else if (exp_q[0]) begin
            cmd_q   <= '{start: 1'b1, square: 1'b0};
            op_a_q  <= acc_q;
            op_b_q  <= sq_q;
            state_q <= S_MUL;
          end else begin
            cmd_q   <= '{start: 1'b1, square: 1'b1};
            op_a_q  <= sq_q;
            state_q <= S_SQR;
          end
        end
        S_MUL: begin
          if (mm_done) begin
            acc_q   <= mm_result;
            cmd_q   <= '{start: 1'b1, square: 1'b1};
            op_a_q  <= sq_q;
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_done) begin
            sq_q    <= mm_result;
            exp_q   <= exp_q >> 1;
            state_q <= S_BIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            power_mod_q <= acc_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = power_mod_q;

endmodule

FILE: design/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks for the modular exponentiation core
// ----------------------------------------------------------------------------
module mexp_checker #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned EXP_WIDTH   = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [VALUE_WIDTH-1:0] base_i,
  input logic [EXP_WIDTH-1:0]   exponent_i,
  input logic [VALUE_WIDTH-1:0] modulus_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [VALUE_WIDTH-1:0] power_mod_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
  else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(power_mod_o))
  else $error("stalled result changed");

  // an accepted transaction keeps the input side busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
  else $error("input not stalled after accept");

  // a new result only comes out of a busy core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
  else $error("result without transaction in flight");

  // an accepted zero exponent, with modulus equal to base, never shows up as a result in the cycle after accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (exponent_i == '0) && (modulus_i == base_i)
      |=> !$rose(out_valid_o))
  else $error("result came out one cycle after accept");

endmodule

bind modular_exponentiation_core mexp_checker #(
  .VALUE_WIDTH(VALUE_WIDTH),
  .EXP_WIDTH  (EXP_WIDTH)
) u_mexp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .base_i     (base_i),
  .exponent_i (exponent_i),
  .modulus_i  (modulus_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .power_mod_o(power_mod_o)
);

FILE: bench/modular_exponentiation_core_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core_test
// drives base, exponent and modulus transactions into the core and checks every
// power_mod against a square-and-multiply predictor kept in a scoreboard; runs
// directed corner cases, then random operands under four idle and stall phases
// ----------------------------------------------------------------------------
module modular_exponentiation_core_test;
  import mexp_pkg::*;

  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned EXP_WIDTH     = 32;
  localparam int unsigned ITEMS_PER_PHASE = 30;
  localparam int unsigned DRAIN_CYCLES  = 50;
  localparam longint unsigned CYCLE_LIMIT = 4000000;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [EXP_WIDTH-1:0]   exp_t;

  class power_mod_scoreboard;
    value_t      pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function value_t power_mod_of(value_t b, exp_t e, value_t m);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned mm;
      exp_t            bits;
      if (e == '0) return value_t'(1);
      if (m == '0) return '0;
      mm   = m;
      sq   = longint'(b) % mm;
      acc  = 1 % mm;
      bits = e;
      while (bits != '0) begin
        if (bits[0]) acc = (acc * sq) % mm;
        sq   = (sq * sq) % mm;
        bits = bits >> 1;
      end
      return acc[VALUE_WIDTH-1:0];
    endfunction

    function void note_operands(value_t b, exp_t e, value_t m);
      pending_q.push_back(power_mod_of(b, e, m));
    endfunction

    function void check_power(value_t actual);
      value_t predicted;
      if (pending_q.size() == 0) begin
        $error("power_mod: expected none, actual %0h", actual);
        mismatches++;
      end else begin
        predicted = pending_q.pop_front();
        if (actual !== predicted) begin
          $error("power_mod: expected %0h, actual %0h", predicted, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending_count();
      return pending_q.size();
    endfunction
  endclass

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  value_t base      = '0;
  exp_t   exponent  = '0;
  value_t modulus   = value_t'(1);
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t power_mod;

  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  longint unsigned cycle_count = 0;

  power_mod_scoreboard powers = new();

  modular_exponentiation_core #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .EXP_WIDTH  (EXP_WIDTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .base_i     (base),
    .exponent_i (exponent),
    .modulus_i  (modulus),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .power_mod_o(power_mod)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall and check of every accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) powers.check_power(power_mod);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_operands(value_t b, exp_t e, value_t m);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    base     <= b;
    exponent <= e;
    modulus  <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    powers.note_operands(b, e, m);
  endtask

  task automatic send_random_operands();
    value_t      b;
    exp_t        e;
    value_t      m;
    logic [63:0] emask;
    int unsigned k;
    k     = $urandom_range(1, EXP_WIDTH);
    emask = (64'd1 << k) - 64'd1;
    e     = $urandom;
    if ($urandom_range(3) != 0) e = e & emask[EXP_WIDTH-1:0];
    if ($urandom_range(15) == 0) e = '0;
    case ($urandom_range(7))
      0: m = $urandom_range(1, 255);
      1: m = value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1);
      2: m = '1;
      default: begin
        m = $urandom;
        if (m == '0) m = value_t'(1);
      end
    endcase
    case ($urandom_range(7))
      0: b = '0;
      1: b = '1;
      2: b = m - 1;
      3: b = $urandom_range(0, 15);
      default: b = $urandom;
    endcase
    send_operands(b, e, m);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero exponent, including unit modulus
    send_operands('0, '0, value_t'(1));
    send_operands(value_t'(5), '0, '1);
    send_operands('1, '0, value_t'(1));
    // unit modulus with nonzero exponent
    send_operands('1, exp_t'(1), value_t'(1));
    send_operands(value_t'(9), '1, value_t'(1));
    // field extremes
    send_operands('1, '1, '1);
    send_operands('0, exp_t'(5), value_t'(7));
    send_operands(value_t'(1), '1, value_t'(2));
    send_operands('1, '1, value_t'(2));
    send_operands(value_t'(2), exp_t'(31), '1);
    send_operands(value_t'(2), exp_t'(32), '1);
    send_operands('1, exp_t'(2), 32'hFFFF_FFFB);
    send_operands(32'hFFFF_FFFE, '1, '1);
    send_operands(value_t'(12345), exp_t'(65537), 32'hFFFF_FFFB);
    send_operands(value_t'(7), 32'h8000_0000, 32'h8000_0000);
    send_operands(32'h8000_0000, exp_t'(3), '1);
    // base above modulus
    send_operands(value_t'(10), exp_t'(1), value_t'(3));
    send_operands(32'hDEAD_BEEF, 32'h1234_5678, value_t'(1000));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_operands();
    end
    in_valid <= 1'b0;

    while (powers.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (powers.mismatches == 0 && powers.pending_count() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
